// File: hw/rtl/header_line_unfolder_core_macros.svh
// ---------------------------------------------------------------------------
// Header line unfolder assertion macros
// Concurrent assertion wrappers used by the unfolder top level.
// ---------------------------------------------------------------------------
`ifndef HEADER_LINE_UNFOLDER_CORE_MACROS_SVH
`define HEADER_LINE_UNFOLDER_CORE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising clock edge outside reset.
`define HLU_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("HLU assertion failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define HLU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("HLU assertion failed");
`else
`define HLU_ASSERT_IMPL(label, clk, rst, ante, cons)
`define HLU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: hw/rtl/hlu_pkg.sv
// ---------------------------------------------------------------------------
// Header line unfolder package
// Character codes, scan modes and the result group passed between stages.
// ---------------------------------------------------------------------------
`default_nettype none

package hlu_pkg;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_SP = 8'h20;
   localparam logic [7:0] CHAR_HT = 8'h09;

   localparam int unsigned MAX_RESULTS = 3;

   typedef enum logic [4:0] {
      MODE_TEXT = 5'b00001,
      MODE_CR   = 5'b00010,
      MODE_CRLF = 5'b00100,
      MODE_SKIP = 5'b01000,
      MODE_PASS = 5'b10000
   } scan_mode_type;

   // Up to three results caused by one request. A count of zero means the
   // request produced nothing; a bare end marker has count one, has_byte zero.
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] bytes;
      logic [1:0]                  count;
      logic                        has_byte;
      logic                        body_end;
   } hlu_group_type;

endpackage

`default_nettype wire

// File: hw/rtl/hlu_if.sv
// ---------------------------------------------------------------------------
// Header line unfolder channels
// Valid/ready interfaces for the byte request and the result channels.
// ---------------------------------------------------------------------------
`default_nettype none

interface hlu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_body;

   modport source (output valid, output data_byte, output end_of_body, input ready);
   modport sink   (input valid, input data_byte, input end_of_body, output ready);
endinterface

interface hlu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       has_byte;
   logic       last_of_run;
   logic       body_done;

   modport source (output valid, output out_byte, output has_byte,
                   output last_of_run, output body_done, input ready);
   modport sink   (input valid, input out_byte, input has_byte,
                   input last_of_run, input body_done, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/hlu_scan.sv
// ---------------------------------------------------------------------------
// Header line unfolder scan stage
// Input register, scan mode register and the per-byte expansion logic.
// ---------------------------------------------------------------------------
`default_nettype none

module hlu_scan (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [7:0]            req_data_byte,
   input  wire logic                  req_end_of_body,
   output logic                       grp_valid,
   input  wire logic                  grp_ready,
   output hlu_pkg::hlu_group_type     grp
);
   import hlu_pkg::*;

   logic          in_valid_ff;
   logic          in_valid_in;
   logic [7:0]    in_byte_ff;
   logic          in_last_ff;
   scan_mode_type mode_ff;
   scan_mode_type mode_in;
   scan_mode_type mode_nx;
   logic          advance;
   logic          is_lwsp;
   logic [MAX_RESULTS-1:0][7:0] bytes;
   logic [1:0]    cnt;

   assign advance   = in_valid_ff && grp_ready;
   assign req_ready = !in_valid_ff || grp_ready;
   assign grp_valid = in_valid_ff;
   assign is_lwsp   = (in_byte_ff == CHAR_SP) || (in_byte_ff == CHAR_HT);

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      bytes   = '0;
      cnt     = 2'd0;
      mode_nx = mode_ff;
      unique case (mode_ff)
         MODE_CR: begin
            if (in_byte_ff == CHAR_LF) begin
               mode_nx = MODE_CRLF;
            end else if (in_byte_ff == CHAR_CR) begin
               // The earlier CR is plain text; the new one is held.
               bytes[0] = CHAR_CR;
               cnt      = 2'd1;
            end else begin
               bytes[0] = CHAR_CR;
               bytes[1] = in_byte_ff;
               cnt      = 2'd2;
               mode_nx  = MODE_TEXT;
            end
         end
         MODE_CRLF: begin
            if (is_lwsp) begin
               bytes[0] = CHAR_SP;
               cnt      = 2'd1;
               mode_nx  = MODE_SKIP;
            end else begin
               bytes[0] = CHAR_CR;
               bytes[1] = CHAR_LF;
               bytes[2] = in_byte_ff;
               cnt      = 2'd3;
               mode_nx  = MODE_PASS;
            end
         end
         MODE_PASS: begin
            bytes[0] = in_byte_ff;
            cnt      = 2'd1;
         end
         MODE_SKIP: begin
            if (is_lwsp) begin
               cnt = 2'd0;
            end else if (in_byte_ff == CHAR_CR) begin
               mode_nx = MODE_CR;
            end else begin
               bytes[0] = in_byte_ff;
               cnt      = 2'd1;
               mode_nx  = MODE_TEXT;
            end
         end
         default: begin
            if (in_byte_ff == CHAR_CR) begin
               mode_nx = MODE_CR;
            end else begin
               bytes[0] = in_byte_ff;
               cnt      = 2'd1;
               mode_nx  = MODE_TEXT;
            end
         end
      endcase

      // At the end of the body a held CR or CR LF is flushed. A held CR follows
      // at most one byte, and a held CR LF follows none.
      if (in_last_ff) begin
         if (mode_nx == MODE_CR) begin
            if (cnt == 2'd0) begin
               bytes[0] = CHAR_CR;
               cnt      = 2'd1;
            end else begin
               bytes[1] = CHAR_CR;
               cnt      = 2'd2;
            end
         end else if (mode_nx == MODE_CRLF) begin
            bytes[0] = CHAR_CR;
            bytes[1] = CHAR_LF;
            cnt      = 2'd2;
         end
         mode_nx = MODE_TEXT;
      end

      grp.has_byte = (cnt != 2'd0);
      grp.body_end = in_last_ff;
      grp.bytes    = bytes;
      // A body that ends on a dropped byte still gets a bare end marker.
      grp.count    = (in_last_ff && (cnt == 2'd0)) ? 2'd1 : cnt;
      mode_in      = advance ? mode_nx : mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_TEXT;
      end else begin
         in_valid_ff <= in_valid_in;
         mode_ff     <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_end_of_body;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/hlu_emit.sv
// ---------------------------------------------------------------------------
// Header line unfolder result stage
// Holds the results of one request and sends them one per cycle while the receiver is ready.
// ---------------------------------------------------------------------------
`default_nettype none

module hlu_emit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  grp_valid,
   output logic                       grp_ready,
   input  wire hlu_pkg::hlu_group_type grp,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_has_byte,
   output logic                       rsp_last_of_run,
   output logic                       rsp_body_done
);
   import hlu_pkg::*;

   logic [1:0]                  cnt_ff;
   logic [1:0]                  cnt_in;
   logic [MAX_RESULTS-1:0][7:0] bytes_ff;
   logic [MAX_RESULTS-1:0][7:0] bytes_in;
   logic                        has_ff;
   logic                        end_ff;
   logic                        load;
   logic                        take;

   assign take      = rsp_valid && rsp_ready;
   // A new group may enter as the final result of the current one leaves.
   assign grp_ready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ready);
   assign load      = grp_valid && grp_ready;

   assign rsp_valid       = (cnt_ff != 2'd0);
   assign rsp_out_byte    = bytes_ff[0];
   assign rsp_has_byte    = has_ff;
   assign rsp_last_of_run = (cnt_ff == 2'd1);
   assign rsp_body_done   = (cnt_ff == 2'd1) && end_ff;

   always_comb begin
      if (load) begin
         cnt_in   = grp.count;
         bytes_in = grp.bytes;
      end else if (take) begin
         cnt_in   = cnt_ff - 2'd1;
         bytes_in = {8'h00, bytes_ff[MAX_RESULTS-1:1]};
      end else begin
         cnt_in   = cnt_ff;
         bytes_in = bytes_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      if (load) begin
         has_ff <= grp.has_byte;
         end_ff <= grp.body_end;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/header_line_unfolder_core.sv
// ---------------------------------------------------------------------------
// Header line unfolder
// Unfolds a header field body arriving one byte per request.
// ---------------------------------------------------------------------------
// The req channel carries one body byte per request with end_of_body on the
// last byte. Each CR LF followed by spaces or tabs becomes one space and the
// whitespace run is dropped; after the first unfolded-free CR LF the rest of
// the body passes unchanged. A held CR or CR LF is flushed at end of body.
// The rsp channel returns zero to three results per request; last_of_run
// marks the final result of a request and body_done the final one of a body.
// A body ending on a dropped byte yields a bare marker with has_byte low.
// Path from request acceptance to its first result: input register, then
// result register. Throughput: one request per cycle while each request yields
// at most one result and the receiver is ready; a request with two or three
// results holds the result register while they leave in turn through the single
// result port. Silent requests produce nothing.
// When the receiver stalls, results hold in the result register and one more
// request waits in the input register before req ready drops.
// Synchronous reset empties both registers and returns to normal text mode.
// ---------------------------------------------------------------------------
`default_nettype none

`include "header_line_unfolder_core_macros.svh"

module header_line_unfolder_core (
   input  wire logic clock,
   input  wire logic reset,
   hlu_req_if.sink   req_chan,
   hlu_rsp_if.source rsp_chan
);
   import hlu_pkg::*;

   logic          grp_valid;
   logic          grp_ready;
   hlu_group_type grp;

   hlu_scan u_scan (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_chan.valid),
      .req_ready       (req_chan.ready),
      .req_data_byte   (req_chan.data_byte),
      .req_end_of_body (req_chan.end_of_body),
      .grp_valid       (grp_valid),
      .grp_ready       (grp_ready),
      .grp             (grp)
   );

   hlu_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .grp_valid       (grp_valid),
      .grp_ready       (grp_ready),
      .grp             (grp),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_out_byte    (rsp_chan.out_byte),
      .rsp_has_byte    (rsp_chan.has_byte),
      .rsp_last_of_run (rsp_chan.last_of_run),
      .rsp_body_done   (rsp_chan.body_done)
   );

   // The end of a body is always the end of a request's results.
   `HLU_ASSERT_IMPL(a_done_is_last, clock, reset,
                    rsp_chan.valid && rsp_chan.body_done, rsp_chan.last_of_run)
   // A result without a byte only ever closes a body.
   `HLU_ASSERT_IMPL(a_bare_marker_ends_body, clock, reset,
                    rsp_chan.valid && !rsp_chan.has_byte, rsp_chan.body_done)
   // Results of one request continue until the last of them is taken.
   `HLU_ASSERT_NEXT(a_run_continues, clock, reset,
                    rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_of_run,
                    rsp_chan.valid)

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Header line unfolder testbench
// A table of directed requests, then random header bodies, is driven into
// the unfolder under three idle patterns and one long receiver stall. Every
// result is checked against an in-bench unfolding predictor or typed expectation.
// ---------------------------------------------------------------------------

module tb;

   import hlu_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_CYCLES  = 300;
   localparam int MAX_REPORTS  = 40;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       last_of_run;
      logic       body_done;
   } unfold_result_type;

   // One request with its typed expectation, used only where typed is set.
   typedef struct packed {
      logic [7:0]                data;
      logic                      eob;
      logic                      typed;
      logic [1:0]                count;
      unfold_result_type [2:0]   entries;
   } unfold_row_type;

   logic clock;
   logic reset;

   hlu_req_if req_bus ();
   hlu_rsp_if rsp_bus ();

   header_line_unfolder_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   scan_mode_type     unfold_state = MODE_TEXT;
   unfold_result_type expected_results [$];
   unfold_row_type    directed_rows [$];
   unfold_row_type    offered_row;
   int                mismatch_count = 0;
   int                cycle_count = 0;
   int                send_idle_pct;
   int                rsp_idle_pct;
   logic              stall_request = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic unfold_result_type mk_result(input logic [7:0] b, input logic has,
                                                   input logic last, input logic done);
      unfold_result_type r;
      r.out_byte    = b;
      r.has_byte    = has;
      r.last_of_run = last;
      r.body_done   = done;
      return r;
   endfunction

   function automatic unfold_row_type mk_row(input logic [7:0] b, input logic eob,
                                             input logic typed, input logic [1:0] count,
                                             input unfold_result_type e0);
      unfold_row_type row;
      row.data       = b;
      row.eob        = eob;
      row.typed      = typed;
      row.count      = count;
      row.entries    = '0;
      row.entries[0] = e0;
      return row;
   endfunction

   function automatic logic is_blank(input logic [7:0] b);
      return (b == CHAR_SP) || (b == CHAR_HT);
   endfunction

   // Advances the unfolding state by one byte and returns the results it causes.
   function automatic int unfold_byte(input logic [7:0] b, input logic eob,
                                      output unfold_result_type [2:0] group);
      logic [2:0][7:0] txt;
      int n;
      txt = '0;
      n = 0;
      group = '0;
      case (unfold_state)
         MODE_CR: begin
            if (b == CHAR_LF) begin
               unfold_state = MODE_CRLF;
            end else if (b == CHAR_CR) begin
               txt[0] = CHAR_CR;
               n = 1;
            end else begin
               txt[0] = CHAR_CR;
               txt[1] = b;
               n = 2;
               unfold_state = MODE_TEXT;
            end
         end
         MODE_CRLF: begin
            if (is_blank(b)) begin
               txt[0] = CHAR_SP;
               n = 1;
               unfold_state = MODE_SKIP;
            end else begin
               txt[0] = CHAR_CR;
               txt[1] = CHAR_LF;
               txt[2] = b;
               n = 3;
               unfold_state = MODE_PASS;
            end
         end
         MODE_PASS: begin
            txt[0] = b;
            n = 1;
         end
         MODE_SKIP: begin
            if (!is_blank(b)) begin
               if (b == CHAR_CR) begin
                  unfold_state = MODE_CR;
               end else begin
                  txt[0] = b;
                  n = 1;
                  unfold_state = MODE_TEXT;
               end
            end
         end
         default: begin
            if (b == CHAR_CR) begin
               unfold_state = MODE_CR;
            end else begin
               txt[0] = b;
               n = 1;
               unfold_state = MODE_TEXT;
            end
         end
      endcase
      // A CR or CR LF still held at the end of the body is flushed.
      if (eob) begin
         if (unfold_state == MODE_CR) begin
            txt[n] = CHAR_CR;
            n++;
         end else if (unfold_state == MODE_CRLF) begin
            txt[0] = CHAR_CR;
            txt[1] = CHAR_LF;
            n = 2;
         end
         unfold_state = MODE_TEXT;
      end
      if (n == 0) begin
         if (!eob) return 0;
         group[0] = mk_result(8'h00, 1'b0, 1'b1, 1'b1);
         return 1;
      end
      for (int k = 0; k < n; k++) begin
         group[k] = mk_result(txt[k], 1'b1, k == n - 1, (k == n - 1) && eob);
      end
      return n;
   endfunction

   // Result check first, then expectations for a request taken at this edge.
   always @(posedge clock) begin
      unfold_result_type       actual;
      unfold_result_type       wanted;
      unfold_result_type [2:0] group;
      int                      n;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            actual = mk_result(rsp_bus.out_byte, rsp_bus.has_byte,
                               rsp_bus.last_of_run, rsp_bus.body_done);
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: unexpected result byte=%02h has=%0b last=%0b done=%0b",
                           $time, actual.out_byte, actual.has_byte,
                           actual.last_of_run, actual.body_done);
            end else begin
               wanted = expected_results.pop_front();
               if (actual !== wanted) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("%0t: expected %02h/%0b/%0b/%0b actual %02h/%0b/%0b/%0b",
                              $time, wanted.out_byte, wanted.has_byte,
                              wanted.last_of_run, wanted.body_done,
                              actual.out_byte, actual.has_byte,
                              actual.last_of_run, actual.body_done);
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            n = unfold_byte(req_bus.data_byte, req_bus.end_of_body, group);
            if (offered_row.typed) begin
               n = offered_row.count;
               group = offered_row.entries;
            end
            for (int k = 0; k < n; k++) expected_results.push_back(group[k]);
         end
      end
   end

   // Receiver: random idling, plus one long hold-off on request.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else if (stall_request) begin
            rsp_bus.ready = 1'b0;
            stall_request = 1'b0;
            hold_left = HOLD_CYCLES - 1;
         end else begin
            rsp_bus.ready = ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   task automatic send_request(input unfold_row_type row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      offered_row = row;
      req_bus.valid = 1'b1;
      req_bus.data_byte = row.data;
      req_bus.end_of_body = row.eob;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_blank();
      return $urandom_range(1) ? CHAR_SP : CHAR_HT;
   endfunction

   // Builds one body: mostly folds and line breaks with random text between.
   task automatic send_random_body(inout int sent);
      logic [7:0] body [$];
      int len;
      int r;
      len = $urandom_range(10, 1);
      if ($urandom_range(9) == 0) begin
         // Noise body of arbitrary bytes.
         repeat (len) body.push_back(8'($urandom_range(255)));
      end else begin
         while (body.size() < len) begin
            r = $urandom_range(99);
            if (r < 25) begin
               body.push_back(CHAR_CR);
               body.push_back(CHAR_LF);
               repeat ($urandom_range(3, 1)) body.push_back(pick_blank());
            end else if (r < 35) begin
               body.push_back(CHAR_CR);
               body.push_back(CHAR_LF);
               body.push_back(8'($urandom_range(255)));
            end else if (r < 43) begin
               body.push_back(CHAR_CR);
            end else if (r < 48) begin
               body.push_back(CHAR_LF);
            end else if (r < 56) begin
               body.push_back(pick_blank());
            end else begin
               body.push_back(8'($urandom_range(255)));
            end
         end
         r = $urandom_range(99);
         if (r < 15) begin
            body.push_back(CHAR_CR);
         end else if (r < 25) begin
            body.push_back(CHAR_CR);
            body.push_back(CHAR_LF);
         end else if (r < 35) begin
            body.push_back(CHAR_CR);
            body.push_back(CHAR_LF);
            body.push_back(pick_blank());
         end
      end
      foreach (body[i]) begin
         send_request(mk_row(body[i], i == body.size() - 1, 1'b0, 2'd0, '0));
         sent++;
      end
   endtask

   initial begin
      int sent;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.data_byte = 8'h00;
      req_bus.end_of_body = 1'b0;
      offered_row = '0;
      send_idle_pct = 28;
      rsp_idle_pct = 72;
      sent = 0;

      directed_rows.push_back(mk_row("A",     1'b0, 1'b1, 2'd1,
                                     mk_result("A",   1'b1, 1'b1, 1'b0)));
      directed_rows.push_back(mk_row(8'h00,   1'b0, 1'b1, 2'd1,
                                     mk_result(8'h00, 1'b1, 1'b1, 1'b0)));
      directed_rows.push_back(mk_row(8'hFF,   1'b0, 1'b1, 2'd1,
                                     mk_result(8'hFF, 1'b1, 1'b1, 1'b0)));
      // A held CR with more body to come produces nothing.
      directed_rows.push_back(mk_row(CHAR_CR, 1'b0, 1'b1, 2'd0, '0));
      directed_rows.push_back(mk_row(CHAR_LF, 1'b0, 1'b0, 2'd0, '0));
      directed_rows.push_back(mk_row(CHAR_SP, 1'b0, 1'b0, 2'd0, '0));
      directed_rows.push_back(mk_row(CHAR_HT, 1'b0, 1'b0, 2'd0, '0));
      // CR inside a fold's whitespace, then CR after CR.
      directed_rows.push_back(mk_row(CHAR_CR, 1'b0, 1'b0, 2'd0, '0));
      directed_rows.push_back(mk_row(CHAR_CR, 1'b0, 1'b0, 2'd0, '0));
      directed_rows.push_back(mk_row("x",     1'b0, 1'b0, 2'd0, '0));
      // A CR LF without whitespace switches to pass-through.
      directed_rows.push_back(mk_row(CHAR_CR, 1'b0, 1'b0, 2'd0, '0));
      directed_rows.push_back(mk_row(CHAR_LF, 1'b0, 1'b0, 2'd0, '0));
      directed_rows.push_back(mk_row("y",     1'b0, 1'b0, 2'd0, '0));
      directed_rows.push_back(mk_row(CHAR_CR, 1'b0, 1'b0, 2'd0, '0));
      directed_rows.push_back(mk_row(CHAR_SP, 1'b1, 1'b0, 2'd0, '0));
      // Body ending on a held CR flushes it.
      directed_rows.push_back(mk_row(CHAR_CR, 1'b1, 1'b1, 2'd1,
                                     mk_result(CHAR_CR, 1'b1, 1'b1, 1'b1)));
      directed_rows.push_back(mk_row(CHAR_CR, 1'b0, 1'b0, 2'd0, '0));
      directed_rows.push_back(mk_row(CHAR_LF, 1'b1, 1'b0, 2'd0, '0));
      directed_rows.push_back(mk_row(CHAR_CR, 1'b0, 1'b0, 2'd0, '0));
      directed_rows.push_back(mk_row(CHAR_LF, 1'b0, 1'b0, 2'd0, '0));
      directed_rows.push_back(mk_row(CHAR_HT, 1'b0, 1'b0, 2'd0, '0));
      // Body ending on a dropped blank gives a bare end marker.
      directed_rows.push_back(mk_row(CHAR_SP, 1'b1, 1'b1, 2'd1,
                                     mk_result(8'h00, 1'b0, 1'b1, 1'b1)));
      directed_rows.push_back(mk_row(8'h80,   1'b1, 1'b1, 2'd1,
                                     mk_result(8'h80, 1'b1, 1'b1, 1'b1)));

      repeat (8) @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i]);
         sent++;
      end

      while (sent < 100) send_random_body(sent);
      send_idle_pct = 72;
      rsp_idle_pct = 28;
      while (sent < 200) send_random_body(sent);
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      stall_request = 1'b1;
      while (sent < 310) send_random_body(sent);
      req_bus.valid = 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
